/* src/mmf_pkg.sv */
// ----------------------------------------------------------------------------
// mmf_pkg: shared types and constants for the moving median filter
// Sample type and default window size, used by the interfaces and modules.
// ----------------------------------------------------------------------------
package mmf_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int WINDOW_SIZE_DEF = 5;
  localparam int WINDOW_SIZE_MAX = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage : mmf_pkg

/* src/mmf_if.sv */
// ----------------------------------------------------------------------------
// mmf_in_if / mmf_out_if: valid/ready channels of the moving median filter
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface mmf_in_if;
  logic             valid;
  logic             ready;
  mmf_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface : mmf_in_if

interface mmf_out_if;
  logic             valid;
  logic             ready;
  mmf_pkg::sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface : mmf_out_if

/* src/mmf_rank_sel.sv */
// ----------------------------------------------------------------------------
// mmf_rank_sel: parallel rank selection over the sample window
// Ranks every valid slot by pairwise compares and picks the one at count/2.
// ----------------------------------------------------------------------------
module mmf_rank_sel #(
  parameter int WINDOW_SIZE = mmf_pkg::WINDOW_SIZE_DEF,
  parameter int CNT_W       = $clog2(WINDOW_SIZE + 1)
) (
  input  mmf_pkg::sample_t             window [WINDOW_SIZE],
  input  logic             [CNT_W-1:0] valid_count,
  output mmf_pkg::sample_t             median
);
  import mmf_pkg::*;

  logic [CNT_W-1:0] target;
  logic [CNT_W-1:0] rank  [WINDOW_SIZE];
  logic             slot_ok [WINDOW_SIZE];

  assign target = valid_count >> 1;

  always_comb begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      slot_ok[i] = (CNT_W'(i) < valid_count);
    end
  end

  // Ties break on slot index, so every valid slot gets a distinct rank.
  always_comb begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_SIZE; j++) begin
        if (slot_ok[j] && ((window[j] < window[i]) ||
                           ((window[j] == window[i]) && (j < i)))) begin
          rank[i] = rank[i] + CNT_W'(1);
        end
      end
    end
  end

  // At most one valid slot matches (exactly one when the count is nonzero); OR the masked samples together.
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (slot_ok[i] && (rank[i] == target)) begin
        median = median | window[i];
      end
    end
  end

endmodule : mmf_rank_sel

/* src/moving_median_filter_unit.sv */
// ----------------------------------------------------------------------------
// moving_median_filter_unit: running median over a circular sample window
// Median of the last WINDOW_SIZE signed 16-bit samples, one per transaction.
// ----------------------------------------------------------------------------
// Each accepted sample is written into a circular window of WINDOW_SIZE
// slots (1 to 15) and produces exactly one median transaction: the element
// at sorted position count/2 of the valid samples, count being the number of
// samples seen since reset capped at WINDOW_SIZE (the upper median when the
// count is even). The unit takes one sample per clock cycle while the
// median channel keeps up. The accepting edge writes the window register;
// the result of the pairwise rank compares is then loaded into the output
// register as soon as it is free, and the median is offered from there.
// The rank network is WINDOW_SIZE x WINDOW_SIZE 16-bit compares plus a
// per-slot population count, and this path sets the clock.
// A median waiting on out_if.ready does not block input as long as the
// ranking stage is free.
module moving_median_filter_unit #(
  parameter int WINDOW_SIZE = mmf_pkg::WINDOW_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mmf_in_if.sink    in_if,
  mmf_out_if.source out_if
);
  import mmf_pkg::*;

  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

  // Window storage and fill state
  sample_t          window_r [WINDOW_SIZE];
  logic [IDX_W-1:0] wr_pos_r;
  logic [IDX_W-1:0] wr_pos_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Ranking stage and output register
  logic    rank_valid_r;
  logic    rank_valid_nxt;
  sample_t rank_median;
  sample_t median_r;
  logic    out_valid_r;

  logic in_fire;
  logic out_adv;

  // Output register can load when empty or being drained this cycle.
  assign out_adv     = !out_valid_r || out_if.ready;
  // Accept when the ranking stage is empty or moves on this cycle.
  assign in_if.ready = !rank_valid_r || out_adv;
  assign in_fire     = in_if.valid && in_if.ready;

  assign out_if.valid  = out_valid_r;
  assign out_if.median = median_r;

  // Advance the write index and wrap at the window size.
  assign wr_pos_nxt = (wr_pos_r == IDX_W'(WINDOW_SIZE - 1)) ? '0 : wr_pos_r + IDX_W'(1);
  // Grow the count until the window is full, then hold.
  assign count_nxt  = (count_r == CNT_W'(WINDOW_SIZE)) ? count_r : count_r + CNT_W'(1);

  assign rank_valid_nxt = in_fire || (rank_valid_r && !out_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r     <= '0;
      count_r      <= '0;
      rank_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rank_valid_r <= rank_valid_nxt;
      if (in_fire) begin
        wr_pos_r <= wr_pos_nxt;
        count_r  <= count_nxt;
      end
      if (out_adv) begin
        out_valid_r <= rank_valid_r;
      end
    end
  end

  // Write the new sample into its slot; slots past the count are never read.
  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (in_fire && (wr_pos_r == IDX_W'(i))) begin
        window_r[i] <= in_if.sample;
      end
    end
  end

  // The window only changes on acceptance, which happens only when the
  // ranking stage hands off, so it always reflects the item being ranked.
  mmf_rank_sel #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .CNT_W       (CNT_W)
  ) u_rank_sel (
    .window      (window_r),
    .valid_count (count_r),
    .median      (rank_median)
  );

  // Capture the median; hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (out_adv && rank_valid_r) begin
      median_r <= rank_median;
    end
  end

endmodule : moving_median_filter_unit

/* test/moving_median_filter_unit_chk.sv */
// ----------------------------------------------------------------------------
// moving_median_filter_unit_chk: median prediction and result comparison
// Watches both channels of the filter. Each accepted sample updates a private
// copy of the circular window and queues the median that the unit owes. Each
// accepted median is compared with the oldest one queued.
// ----------------------------------------------------------------------------
module moving_median_filter_unit_chk
  import mmf_pkg::*;
#(
  parameter int WINDOW = WINDOW_SIZE_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_ready,
  input  sample_t in_sample,
  input  logic    out_valid,
  input  logic    out_ready,
  input  sample_t out_median,
  output int      mismatch_count,
  output int      medians_owed
);

  sample_t     window_copy [WINDOW];
  int unsigned write_slot;
  int unsigned filled;
  sample_t     owed_medians [$];
  int          errs;

  // Rank each valid slot; ties go to the lower slot, so exactly one slot
  // lands on rank filled/2 (the upper median for an even count).
  function automatic sample_t rank_median();
    int unsigned rank;
    sample_t     med;
    med = '0;
    for (int i = 0; i < filled; i++) begin
      rank = 0;
      for (int j = 0; j < filled; j++) begin
        if (window_copy[j] < window_copy[i] ||
            (window_copy[j] == window_copy[i] && j < i)) begin
          rank++;
        end
      end
      if (rank == filled / 2) begin
        med = window_copy[i];
      end
    end
    return med;
  endfunction

  task automatic report_bad(input string what, input sample_t want, input sample_t got);
    if (errs < 10) begin
      $display("%m: %s: expected %0d, got %0d", what, want, got);
    end
    errs++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (window_copy[k]) window_copy[k] = '0;
      write_slot = 0;
      filled     = 0;
      errs       = 0;
      owed_medians.delete();
    end else begin
      // Retire the result transaction first; a sample taken at this edge
      // cannot have produced it.
      if (out_valid && out_ready) begin
        if (owed_medians.size() == 0) begin
          report_bad("median with nothing outstanding", '0, out_median);
        end else if (out_median !== owed_medians[0]) begin
          report_bad("median mismatch", owed_medians[0], out_median);
          void'(owed_medians.pop_front());
        end else begin
          void'(owed_medians.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        window_copy[write_slot] = in_sample;
        write_slot = (write_slot + 1 >= WINDOW) ? 0 : write_slot + 1;
        if (filled < WINDOW) begin
          filled++;
        end
        owed_medians.push_back(rank_median());
      end
    end
    mismatch_count <= errs;
    medians_owed   <= owed_medians.size();
  end

endmodule : moving_median_filter_unit_chk

/* test/moving_median_filter_unit_tb.sv */
// ----------------------------------------------------------------------------
// moving_median_filter_unit_tb: running median filter testbench
// Feeds a directed set of samples (range ends, partly filled window, ties)
// followed by random samples through bursty input traffic, while the median
// channel stalls on its own pattern. A separate checker predicts every median.
// ----------------------------------------------------------------------------
module moving_median_filter_unit_tb;
  import mmf_pkg::*;

  localparam int WINDOW          = WINDOW_SIZE_DEF;
  localparam int DIRECTED_N      = 24;
  localparam int RANDOM_N        = 1726;
  localparam int TOTAL_N         = DIRECTED_N + RANDOM_N;
  // Sample index at which the sender stops until every median is back.
  localparam int DRAIN_PAUSE_AT  = 1200;
  // Samples sent before the receiver's one long hold-off starts.
  localparam int HOLD_OFF_AFTER  = 700;
  localparam int HOLD_OFF_CYCLES = 100;
  // Cycles with no transaction on either channel before giving up.
  localparam int STALL_LIMIT     = 2000;

  // Fill the window one sample at a time (odd and even counts, range ends),
  // then a window of equal samples, mixed ties, and range-end alternation.
  localparam sample_t DIRECTED [DIRECTED_N] = '{
    16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
    16'sh0007, 16'sh0007, 16'sh0007, 16'sh0007, 16'sh0007,
    16'shfffb, 16'shfffb, 16'sh0003, 16'sh0003, 16'shfffb,
    16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0000,
    16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff
  };

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int          mismatch_count;
  int          medians_owed;
  int unsigned samples_sent = 0;

  mmf_in_if  in_if ();
  mmf_out_if out_if ();

  always #5 clk = ~clk;

  moving_median_filter_unit #(
    .WINDOW_SIZE (WINDOW)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  moving_median_filter_unit_chk #(
    .WINDOW (WINDOW)
  ) u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_sample      (in_if.sample),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_median     (out_if.median),
    .mismatch_count (mismatch_count),
    .medians_owed   (medians_owed)
  );

  // Mix full-range samples with a narrow band around zero (many ties inside
  // the window) and the range ends.
  function automatic sample_t draw_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1, 2, 3: return sample_t'($urandom_range(0, 8) - 4);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Present one sample and hold it until the unit takes the transaction.
  task automatic offer_sample(input sample_t s);
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
    samples_sent++;
  endtask

  // Sender: bursts of random length, random gaps between them, one pause
  // for a full drain, then wait out the tail and give the verdict.
  initial begin : sample_source
    int unsigned burst_left;
    int unsigned gap;
    sample_t     s;
    burst_left   = 0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int n = 0; n < TOTAL_N; n++) begin
      s = (n < DIRECTED_N) ? DIRECTED[n] : draw_sample();
      if (n == DRAIN_PAUSE_AT) begin
        // Drop valid and wait until no median is outstanding.
        in_if.valid <= 1'b0;
        do @(posedge clk); while (medians_owed != 0);
        burst_left = 0;
      end
      if (burst_left == 0) begin
        // Zero gap keeps valid high into the next burst.
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      offer_sample(s);
      burst_left--;
    end
    in_if.valid <= 1'b0;
    do @(posedge clk); while (medians_owed != 0);
    // Give a stray extra median time to show up.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("moving_median_filter_unit_tb: clean");
    end else begin
      $display("moving_median_filter_unit_tb: errors");
    end
    $finish;
  end

  // Receiver: stretches of steady ready, random ready and short stalls, plus
  // one long hold-off while the sender keeps offering, so the unit fills up
  // and drops in_if.ready.
  initial begin : median_sink
    bit held;
    held         = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      if (!held && samples_sent >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          @(posedge clk);
          out_if.ready <= 1'b0;
        end
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            repeat ($urandom_range(10, 60)) begin
              @(posedge clk);
              out_if.ready <= 1'b1;
            end
          end
          1: begin
            repeat ($urandom_range(5, 30)) begin
              @(posedge clk);
              out_if.ready <= ($urandom_range(0, 3) != 0);
            end
          end
          default: begin
            repeat ($urandom_range(1, 8)) begin
              @(posedge clk);
              out_if.ready <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  initial begin : stall_watch
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("moving_median_filter_unit_tb: errors");
    $finish;
  end

endmodule : moving_median_filter_unit_tb
